[hdl/olst_pkg.sv]
package olst_pkg;

	localparam int DEPTH_DEF       = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	// wide enough for positions, lengths and window bounds at any DEPTH up to 1024
	localparam int CMP_W = 12;

	typedef enum logic [3:0] {
		OP_GET          = 4'd0,
		OP_SET          = 4'd1,
		OP_APPEND       = 4'd2,
		OP_INSERT       = 4'd3,
		OP_REMOVE_AT    = 4'd4,
		OP_REMOVE_VALUE = 4'd5,
		OP_FIRST_MATCH  = 4'd6,
		OP_LAST_MATCH   = 4'd7,
		OP_CONTAINS     = 4'd8,
		OP_CLEAR        = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_WRITE,
		CMD_INSERT,
		CMD_DELETE
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [5:0]  position;
		logic [31:0] item_value;
		logic [5:0]  window_start;
		logic [6:0]  window_span;
		logic        span_whole;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_value;
		logic        found;
		logic [5:0]  match_position;
		logic [6:0]  list_length;
	} rsp_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [CMP_W-1:0] pos;
		logic [CMP_W-1:0] lo;
		logic [CMP_W-1:0] hi;
	} cell_ctl_t;

endpackage

[hdl/olst_cell.sv]
module olst_cell #(
	parameter int VALUE_WIDTH = olst_pkg::VALUE_WIDTH_DEF,
	parameter int INDEX       = 0
) (
	input  logic                   clk,
	input  olst_pkg::cell_ctl_t    ctl,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [VALUE_WIDTH-1:0] lower,
	input  logic [VALUE_WIDTH-1:0] upper,
	output logic [VALUE_WIDTH-1:0] data,
	output logic                   hit_s1
);

	localparam logic [olst_pkg::CMP_W-1:0] IDX = olst_pkg::CMP_W'(INDEX);

	logic [VALUE_WIDTH-1:0] data_q;
	logic                   hit;

	assign data = data_q;

	always_comb begin
		hit = (data_q == value) && (IDX >= ctl.lo) && (IDX < ctl.hi);
	end

	always_ff @(posedge clk) begin
		hit_s1 <= hit;
		case (ctl.cmd)
			olst_pkg::CMD_WRITE: begin
				if (IDX == ctl.pos) data_q <= value;
			end
			olst_pkg::CMD_INSERT: begin
				if (IDX > ctl.pos) data_q <= lower;
				else if (IDX == ctl.pos) data_q <= value;
			end
			olst_pkg::CMD_DELETE: begin
				if (IDX >= ctl.pos) data_q <= upper;
			end
			default: begin
			end
		endcase
	end

endmodule

[hdl/olst_prio.sv]
module olst_prio #(
	parameter int N = olst_pkg::DEPTH_DEF
) (
	input  logic [N-1:0]                hits,
	output logic                        any,
	output logic [olst_pkg::CMP_W-1:0]  lo_idx,
	output logic [olst_pkg::CMP_W-1:0]  hi_idx
);

	always_comb begin
		any    = |hits;
		lo_idx = '0;
		hi_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (hits[i]) lo_idx = olst_pkg::CMP_W'(i);
		end
		for (int i = 0; i < N; i++) begin
			if (hits[i]) hi_idx = olst_pkg::CMP_W'(i);
		end
	end

endmodule

[hdl/ordered_list_store_top.sv]
// channel | valid     | stall     | payload
// req     | req_valid | req_stall | req (olst_pkg::req_t)
// rsp     | rsp_valid | rsp_stall | rsp (olst_pkg::rsp_t)
// A taken item passes a compare state, in which every cell compares its entry with
// the value, then an execute state for the priority encoder, the read mux and the cell shift.
// One item is in work at a time; the result register lets the next item enter while
// the previous result waits. arst_n clears the length and the control; entries are
// not cleared. A stalled result holds the block in its execute state.
module ordered_list_store_top #(
	parameter int DEPTH       = olst_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = olst_pkg::VALUE_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  olst_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output olst_pkg::rsp_t rsp
);

	localparam int CW    = olst_pkg::CMP_W;
	localparam int LEN_W = $clog2(DEPTH + 1);

	olst_pkg::state_t state_q, state_d;
	olst_pkg::req_t   req_q;
	olst_pkg::rsp_t   rsp_q, rsp_d;
	logic             rsp_valid_q;
	logic [LEN_W-1:0] len_q, len_d;

	logic [VALUE_WIDTH-1:0] value;
	logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]       hits;
	logic                   any;
	logic [CW-1:0]          first_idx, last_idx;

	olst_pkg::cell_ctl_t ctl;
	olst_pkg::cmd_t      cmd;
	logic [CW-1:0]       cmd_pos;
	logic [CW-1:0]       pos_c, len_c, span_c, end_c;
	logic [VALUE_WIDTH-1:0] rd;
	logic                fire, accept;

	assign value     = VALUE_WIDTH'(req_q.item_value);
	assign pos_c     = CW'(req_q.position);
	assign len_c     = CW'(len_q);
	assign req_stall = (state_q != olst_pkg::S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign fire      = (state_q == olst_pkg::S_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// search window
	always_comb begin
		span_c = req_q.span_whole ? len_c : CW'(req_q.window_span);
		end_c  = CW'(req_q.window_start) + span_c;
		ctl.lo = '0;
		ctl.hi = len_c;
		if (req_q.opcode == olst_pkg::OP_FIRST_MATCH ||
		    req_q.opcode == olst_pkg::OP_LAST_MATCH) begin
			ctl.lo = CW'(req_q.window_start);
			ctl.hi = (end_c < len_c) ? end_c : len_c;
		end
		ctl.cmd = fire ? cmd : olst_pkg::CMD_HOLD;
		ctl.pos = cmd_pos;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] lower, upper;
		if (i == 0) begin : g_lo0
			assign lower = '0;
		end else begin : g_lo
			assign lower = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_upn
			assign upper = '0;
		end else begin : g_up
			assign upper = cell_data[i+1];
		end
		olst_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.value (value),
			.lower (lower),
			.upper (upper),
			.data  (cell_data[i]),
			.hit_s1(hits[i])
		);
	end

	olst_prio #(.N(DEPTH)) u_prio (
		.hits  (hits),
		.any   (any),
		.lo_idx(first_idx),
		.hi_idx(last_idx)
	);

	always_comb begin
		rd = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (CW'(i) == pos_c) rd = cell_data[i];
		end
	end

	always_comb begin
		rsp_d   = '0;
		len_d   = len_q;
		cmd     = olst_pkg::CMD_HOLD;
		cmd_pos = pos_c;
		case (req_q.opcode) inside
			olst_pkg::OP_GET: begin
				if (pos_c < len_c) rsp_d.read_value = 32'(rd);
				else rsp_d.status = olst_pkg::STAT_RANGE;
			end
			olst_pkg::OP_SET: begin
				if (pos_c < len_c) cmd = olst_pkg::CMD_WRITE;
				else rsp_d.status = olst_pkg::STAT_RANGE;
			end
			olst_pkg::OP_APPEND: begin
				if (len_c >= CW'(DEPTH)) begin
					rsp_d.status = olst_pkg::STAT_FULL;
				end else begin
					cmd     = olst_pkg::CMD_WRITE;
					cmd_pos = len_c;
					len_d   = LEN_W'(len_q + 1'b1);
				end
			end
			olst_pkg::OP_INSERT: begin
				if (pos_c >= len_c) begin
					rsp_d.status = olst_pkg::STAT_RANGE;
				end else if (len_c >= CW'(DEPTH)) begin
					rsp_d.status = olst_pkg::STAT_FULL;
				end else begin
					cmd   = olst_pkg::CMD_INSERT;
					len_d = LEN_W'(len_q + 1'b1);
				end
			end
			olst_pkg::OP_REMOVE_AT: begin
				if (pos_c < len_c) begin
					cmd   = olst_pkg::CMD_DELETE;
					len_d = LEN_W'(len_q - 1'b1);
				end else begin
					rsp_d.status = olst_pkg::STAT_RANGE;
				end
			end
			olst_pkg::OP_REMOVE_VALUE: begin
				if (any) begin
					rsp_d.found          = 1'b1;
					rsp_d.match_position = 6'(first_idx);
					cmd     = olst_pkg::CMD_DELETE;
					cmd_pos = first_idx;
					len_d   = LEN_W'(len_q - 1'b1);
				end
			end
			olst_pkg::OP_FIRST_MATCH, olst_pkg::OP_CONTAINS: begin
				if (any) begin
					rsp_d.found          = 1'b1;
					rsp_d.match_position = 6'(first_idx);
				end
			end
			olst_pkg::OP_LAST_MATCH: begin
				if (any) begin
					rsp_d.found          = 1'b1;
					rsp_d.match_position = 6'(last_idx);
				end
			end
			olst_pkg::OP_CLEAR: begin
				len_d = '0;
			end
			default: begin
			end
		endcase
		rsp_d.list_length = 7'(len_d);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			olst_pkg::S_IDLE: if (accept) state_d = olst_pkg::S_CMP;
			olst_pkg::S_CMP:  state_d = olst_pkg::S_EXEC;
			olst_pkg::S_EXEC: if (fire) state_d = olst_pkg::S_IDLE;
			default:          state_d = olst_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= olst_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
			len_q       <= '0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				rsp_valid_q <= 1'b1;
				len_q       <= len_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
		if (fire) rsp_q <= rsp_d;
	end

	a_accept_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == olst_pkg::S_CMP)
		else $error("accepted item did not enter compare");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(len_q) <= CW'(DEPTH))
		else $error("length above depth");

	a_len_exec_only: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != olst_pkg::S_EXEC |=> $stable(len_q))
		else $error("length changed outside execute");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == olst_pkg::STAT_FULL |-> CW'(len_q) == CW'(DEPTH))
		else $error("full reported below depth");

endmodule
